### rtl/rc4_variant_feedback_stream_cipher_macros.svh
// Assertion helpers used by the RTL of the stream cipher.
`ifndef RC4_VARIANT_FEEDBACK_STREAM_CIPHER_MACROS_SVH
`define RC4_VARIANT_FEEDBACK_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RC4V_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RC4V_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rc4v_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rc4v_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned SBOX_DEPTH = 256;
  localparam int unsigned KLEN_W     = 9;

  // Operation codes carried on the input channel.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SCHED = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  localparam byte_t FEEDBACK_INIT = 8'd15;
  localparam logic [KLEN_W-1:0] KLEN_RESET = 9'd16;

endpackage

`default_nettype wire

### rtl/rc4v_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rc4v_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/rc4_variant_feedback_stream_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// Byte stream cipher in the RC4 family with ciphertext feedback.
// Input channel (in_valid / in_stall) carries one operation per transaction:
// load a key byte into the key store, run the key schedule, or cipher one byte.
// Result channel (out_valid / out_stall) carries one transaction per ciphered
// byte: the output byte and the keystream byte that produced it.
// Key loads are accepted back to back.
// A data byte runs through states D1 to D4 once accepted; its result is registered
// on the result port as D4 completes, and the next item is taken in that same cycle,
// so a new byte waits until the last one finishes. The single S-box memory port sets
// this pace: four dependent reads, the first issued on acceptance, the two swap writes in D3 and D4.
// The key schedule holds in_stall high through the identity fill of all 256
// entries in INIT, then states KA, KB, KC and KD for each of the 256 swap steps
// and states F0 to F4 to pick up the indices and the step.
// Reset clears the indices and step to zero, feedback to 15 and the key length
// to 16. The S-box and key store are not cleared; data bytes are dropped without
// a result until a key schedule has run.
// While the receiver stalls a finished result, the block keeps it on the port
// and holds the last step of the following data byte, so in_stall stays high.
// cfg_we / cfg_wdata write the key length; write it only while the block is idle.

`include "rc4_variant_feedback_stream_cipher_macros.svh"

module rc4_variant_feedback_stream_cipher #(
  parameter int unsigned KEY_DEPTH = 256,
  localparam int unsigned KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_key_index,
  input  wire logic [7:0] in_byte_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte_out,
  output logic [7:0]      out_keystream
);

  // Controller states. The D states cipher one byte, the K states run one
  // swap step of the key schedule, the F states pick up the indices and the step.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_D1   = 4'd1;
  localparam logic [3:0] ST_D2   = 4'd2;
  localparam logic [3:0] ST_D3   = 4'd3;
  localparam logic [3:0] ST_D4   = 4'd4;
  localparam logic [3:0] ST_INIT = 4'd5;
  localparam logic [3:0] ST_KA   = 4'd6;
  localparam logic [3:0] ST_KB   = 4'd7;
  localparam logic [3:0] ST_KC   = 4'd8;
  localparam logic [3:0] ST_KD   = 4'd9;
  localparam logic [3:0] ST_F0   = 4'd10;
  localparam logic [3:0] ST_F1   = 4'd11;
  localparam logic [3:0] ST_F2   = 4'd12;
  localparam logic [3:0] ST_F3   = 4'd13;
  localparam logic [3:0] ST_F4   = 4'd14;

  localparam logic [rc4v_pkg::KLEN_W-1:0] KEY_DEPTH_L = rc4v_pkg::KLEN_W'(KEY_DEPTH);

  logic [3:0] state_r, state_nxt;
  logic       ready_r, ready_nxt;
  rc4v_pkg::byte_t idx_i_r, idx_i_nxt;
  rc4v_pkg::byte_t idx_j_r, idx_j_nxt;
  rc4v_pkg::byte_t idx_k_r, idx_k_nxt;
  rc4v_pkg::byte_t step_w_r, step_w_nxt;
  rc4v_pkg::byte_t feedback_r, feedback_nxt;
  logic [rc4v_pkg::KLEN_W-1:0] klen_r, klen_nxt;
  logic       out_valid_r, out_valid_nxt;

  rc4v_pkg::byte_t cnt_r, cnt_nxt;
  logic [KAW-1:0]  pos_r, pos_nxt;
  rc4v_pkg::byte_t acc_r, acc_nxt;
  rc4v_pkg::byte_t sn_r, sn_nxt;
  rc4v_pkg::byte_t a_r, a_nxt;
  rc4v_pkg::byte_t c_r, c_nxt;
  rc4v_pkg::byte_t data_r, data_nxt;
  logic       fwd_r, fwd_nxt;
  logic       hit_j_r, hit_j_nxt;
  logic       hit_i_r, hit_i_nxt;
  rc4v_pkg::byte_t out_byte_r, out_byte_nxt;
  rc4v_pkg::byte_t out_ks_r, out_ks_nxt;

  logic            s_we;
  rc4v_pkg::byte_t s_waddr, s_wdata, s_raddr, s_rdata;
  logic            k_we;
  logic [KAW-1:0]  k_waddr;
  rc4v_pkg::byte_t k_rdata;

  logic            out_free, in_acc;
  logic [rc4v_pkg::KLEN_W-1:0] len_eff;
  rc4v_pkg::byte_t a_cur, ks, res, k_new, m_addr, next_i;

  rc4v_ram #(
    .WIDTH(8),
    .DEPTH(rc4v_pkg::SBOX_DEPTH)
  ) u_sbox (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  rc4v_ram #(
    .WIDTH(8),
    .DEPTH(KEY_DEPTH)
  ) u_key (
    .clk  (clk),
    .we   (k_we),
    .waddr(k_waddr),
    .wdata(in_byte_in),
    .raddr(pos_r),
    .rdata(k_rdata)
  );

  // A result slot is free when it is empty or its transaction completes now.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) || ((state_r == ST_D4) && out_free));
  assign in_acc   = in_valid && !in_stall;

  // Key length clamped to the range the key store can serve.
  always_comb begin
    if (klen_r == '0) begin
      len_eff = rc4v_pkg::KLEN_W'(1);
    end else if (klen_r > KEY_DEPTH_L) begin
      len_eff = KEY_DEPTH_L;
    end else begin
      len_eff = klen_r;
    end
  end

  assign next_i = idx_i_r + step_w_r;
  // The first data read may collide with the second swap write of the
  // previous byte; the forwarded value is the one that write stores.
  assign a_cur  = fwd_r ? a_r : s_rdata;
  assign k_new  = idx_i_r + idx_k_r + s_rdata;
  assign m_addr = idx_j_r + k_new;
  assign ks     = hit_j_r ? a_r : (hit_i_r ? c_r : s_rdata);
  assign res    = data_r ^ ks;

  always_comb begin
    state_nxt      = state_r;
    ready_nxt      = ready_r;
    idx_i_nxt      = idx_i_r;
    idx_j_nxt      = idx_j_r;
    idx_k_nxt      = idx_k_r;
    step_w_nxt     = step_w_r;
    feedback_nxt   = feedback_r;
    klen_nxt       = cfg_we ? cfg_wdata : klen_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    acc_nxt        = acc_r;
    sn_nxt         = sn_r;
    a_nxt          = a_r;
    c_nxt          = c_r;
    data_nxt       = data_r;
    fwd_nxt        = 1'b0;
    hit_j_nxt      = hit_j_r;
    hit_i_nxt      = hit_i_r;
    out_byte_nxt   = out_byte_r;
    out_ks_nxt     = out_ks_r;
    s_we           = 1'b0;
    s_waddr        = cnt_r;
    s_wdata        = cnt_r;
    s_raddr        = next_i;
    k_we           = 1'b0;
    k_waddr        = in_key_index[KAW-1:0];

    case (state_r)
      ST_IDLE: begin
      end
      ST_D1: begin
        a_nxt     = a_cur;
        s_raddr   = idx_j_r + feedback_r + a_cur;
        state_nxt = ST_D2;
      end
      ST_D2: begin
        idx_j_nxt = idx_k_r + s_rdata;
        s_raddr   = idx_k_r + s_rdata;
        state_nxt = ST_D3;
      end
      ST_D3: begin
        c_nxt     = s_rdata;
        idx_k_nxt = k_new;
        s_we      = 1'b1;
        s_waddr   = idx_i_r;
        s_wdata   = s_rdata;
        s_raddr   = m_addr;
        hit_j_nxt = (m_addr == idx_j_r);
        hit_i_nxt = (m_addr == idx_i_r);
        state_nxt = ST_D4;
      end
      ST_D4: begin
        if (out_free) begin
          s_we          = 1'b1;
          s_waddr       = idx_j_r;
          s_wdata       = a_r;
          fwd_nxt       = (next_i == idx_j_r);
          feedback_nxt  = res;
          out_byte_nxt  = res;
          out_ks_nxt    = ks;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          // Keep reading the keystream entry while the result port is blocked.
          s_raddr = idx_j_r + idx_k_r;
        end
      end
      ST_INIT: begin
        s_we    = 1'b1;
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == 8'hFF) begin
          acc_nxt   = len_eff[7:0];
          pos_nxt   = '0;
          state_nxt = ST_KA;
        end
      end
      ST_KA: begin
        s_raddr   = cnt_r;
        state_nxt = ST_KB;
      end
      ST_KB: begin
        sn_nxt    = s_rdata;
        acc_nxt   = acc_r + k_rdata + s_rdata;
        s_raddr   = acc_r + k_rdata + s_rdata;
        state_nxt = ST_KC;
      end
      ST_KC: begin
        s_we      = 1'b1;
        s_waddr   = cnt_r;
        s_wdata   = s_rdata;
        state_nxt = ST_KD;
      end
      ST_KD: begin
        s_we    = 1'b1;
        s_waddr = acc_r;
        s_wdata = sn_r;
        cnt_nxt = cnt_r + 8'd1;
        if ((rc4v_pkg::KLEN_W'(pos_r) + rc4v_pkg::KLEN_W'(1)) >= len_eff) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + KAW'(1);
        end
        state_nxt = (cnt_r == 8'hFF) ? ST_F0 : ST_KA;
      end
      ST_F0: begin
        s_raddr   = 8'd0;
        state_nxt = ST_F1;
      end
      ST_F1: begin
        idx_i_nxt = s_rdata;
        s_raddr   = 8'd1;
        state_nxt = ST_F2;
      end
      ST_F2: begin
        idx_j_nxt = s_rdata;
        s_raddr   = 8'd2;
        state_nxt = ST_F3;
      end
      ST_F3: begin
        idx_k_nxt = s_rdata;
        s_raddr   = 8'd4;
        state_nxt = ST_F4;
      end
      ST_F4: begin
        step_w_nxt   = {s_rdata[6:0], 1'b1};
        feedback_nxt = rc4v_pkg::FEEDBACK_INIT;
        ready_nxt    = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Decode of a new transaction; taken in IDLE and as D4 completes.
    if (in_acc) begin
      case (in_op)
        rc4v_pkg::OP_LOAD: begin
          k_we = ({1'b0, in_key_index} < KEY_DEPTH_L);
        end
        rc4v_pkg::OP_SCHED: begin
          cnt_nxt   = 8'd0;
          state_nxt = ST_INIT;
        end
        rc4v_pkg::OP_DATA: begin
          if (ready_r) begin
            idx_i_nxt = next_i;
            data_nxt  = in_byte_in;
            state_nxt = ST_D1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ready_r      <= 1'b0;
      idx_i_r      <= '0;
      idx_j_r      <= '0;
      idx_k_r      <= '0;
      step_w_r     <= '0;
      feedback_r   <= rc4v_pkg::FEEDBACK_INIT;
      klen_r       <= rc4v_pkg::KLEN_RESET;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      pos_r        <= '0;
      fwd_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ready_r      <= ready_nxt;
      idx_i_r      <= idx_i_nxt;
      idx_j_r      <= idx_j_nxt;
      idx_k_r      <= idx_k_nxt;
      step_w_r     <= step_w_nxt;
      feedback_r   <= feedback_nxt;
      klen_r       <= klen_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      pos_r        <= pos_nxt;
      fwd_r        <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    sn_r       <= sn_nxt;
    a_r        <= a_nxt;
    c_r        <= c_nxt;
    data_r     <= data_nxt;
    hit_j_r    <= hit_j_nxt;
    hit_i_r    <= hit_i_nxt;
    out_byte_r <= out_byte_nxt;
    out_ks_r   <= out_ks_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte_out  = out_byte_r;
  assign out_keystream = out_ks_r;

  // A byte is ciphered only after a key schedule has completed.
  `RC4V_ASSERT_IMP(a_data_needs_key, clk, rst_n, state_r == ST_D1, ready_r, "cipher without schedule")
  // The step taken from the schedule is always odd.
  `RC4V_ASSERT_IMP(a_step_odd, clk, rst_n, ready_r, step_w_r[0], "even step")
  // Finishing a byte always presents a result in the next cycle.
  `RC4V_ASSERT_NXT(a_result_shown, clk, rst_n, (state_r == ST_D4) && out_free, out_valid, "result lost")
  // Nothing is taken while the schedule or a byte is in flight.
  `RC4V_ASSERT_IMP(a_busy_stalls, clk, rst_n, (state_r != ST_IDLE) && (state_r != ST_D4), in_stall, "input taken while busy")

endmodule

`default_nettype wire

### tb/rc4_variant_feedback_stream_cipher_tb.sv
`timescale 1ns / 1ps

module rc4_variant_feedback_stream_cipher_tb;
  import rc4v_pkg::*;

  // The package names the three live operations. The fourth code carries no
  // operation, and the block must drop it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // A key schedule keeps the block busy after it is accepted and produces no
  // result. Before a key length write, the bench waits long enough for a
  // schedule to finish.
  localparam int SCHED_SETTLE = 1400;
  localparam int DRAIN_CYCLES = 50;
  // This is the long receiver hold-off. It is far longer than a data byte
  // takes, so the block fills up and has to stall its input.
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 110;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [8:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_op;
  byte_t      in_key_index;
  byte_t      in_byte_in;
  logic       out_valid;
  logic       out_stall;
  byte_t      out_byte_out;
  byte_t      out_keystream;

  rc4_variant_feedback_stream_cipher uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_key_index (in_key_index),
    .in_byte_in   (in_byte_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte_out (out_byte_out),
    .out_keystream(out_keystream)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // One ciphered byte as it should appear on the result port.
  typedef struct packed {
    byte_t byte_out;
    byte_t keystream;
  } cipher_out_t;

  // Ciphered bytes still owed by the block, oldest first.
  cipher_out_t pending_bytes[$];

  // This is the bench's own copy of the cipher state. The permutation and the
  // key store start unknown. key_known records which key bytes have been
  // loaded, so that no schedule ever reads a key byte that was never written.
  byte_t      perm[SBOX_DEPTH];
  byte_t      keys[SBOX_DEPTH];
  bit         key_known[SBOX_DEPTH];
  logic [8:0] klen_reg;
  byte_t      pi;
  byte_t      pj;
  byte_t      pk;
  byte_t      stride;
  byte_t      fb_byte;
  bit         keyed;

  int errors;
  // When calm is set, neither side idles. This gives stretches at full rate.
  bit calm;
  // The stimulus raises this flag to ask the receiver for one long hold-off.
  bit hold_req;

  // A key length of zero acts as one, and anything past the store size is
  // clipped to the store size.
  function automatic int used_key_bytes();
    if (klen_reg == 9'd0)
      return 1;
    if (klen_reg > 9'(SBOX_DEPTH))
      return SBOX_DEPTH;
    return int'(klen_reg);
  endfunction

  function automatic byte_t rand_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  // Idle lengths are mostly zero or short, with a rare long one.
  function automatic int idle_len();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // This is the modified key schedule. The permutation starts as the identity,
  // the running index starts at the key length, and the indices and the odd step
  // are taken afterwards from fixed entries; the feedback byte is reset to FEEDBACK_INIT.
  task automatic rekey();
    int    len;
    int    pos;
    byte_t acc;
    byte_t t;
    len = used_key_bytes();
    for (int n = 0; n < SBOX_DEPTH; n++)
      perm[n] = byte_t'(n);
    acc = byte_t'(len);
    pos = 0;
    for (int n = 0; n < SBOX_DEPTH; n++) begin
      acc = acc + keys[pos] + perm[n];
      t = perm[n];
      perm[n] = perm[acc];
      perm[acc] = t;
      pos++;
      if (pos >= len)
        pos = 0;
    end
    pi = perm[0];
    pj = perm[1];
    pk = perm[2];
    stride = {perm[4][6:0], 1'b1};
    fb_byte = FEEDBACK_INIT;
    keyed = 1'b1;
  endtask

  // This advances the cipher state by one accepted transaction. A result is
  // queued only for a data byte that arrives after a schedule has run.
  task automatic cipher_step(input logic [1:0] op, input byte_t kidx, input byte_t data,
                             output bit made);
    byte_t       jt;
    byte_t       at;
    byte_t       t;
    cipher_out_t r;
    made = 1'b0;
    case (op)
      OP_LOAD: begin
        keys[kidx] = data;
        key_known[kidx] = 1'b1;
      end
      OP_SCHED: begin
        rekey();
      end
      OP_DATA: begin
        if (keyed) begin
          jt = pj + fb_byte;
          pi = pi + stride;
          at = jt + perm[pi];
          pj = pk + perm[at];
          pk = pi + pk + perm[pj];
          t = perm[pi];
          perm[pi] = perm[pj];
          perm[pj] = t;
          at = pj + pk;
          r.keystream = perm[at];
          r.byte_out = data ^ r.keystream;
          fb_byte = r.byte_out;
          pending_bytes.push_back(r);
          made = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endtask

  // This offers one transaction and returns once the block has taken it. A
  // back-to-back item keeps in_valid high and only swaps the payload.
  task automatic send_item(input logic [1:0] op, input byte_t kidx, input byte_t data,
                           output bit made);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_key_index <= kidx;
    in_byte_in   <= data;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    cipher_step(op, kidx, data, made);
  endtask

  // This waits until every owed byte has come back, then lets the block settle.
  task automatic settle(input int cycles);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0)
      @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_key_length(input logic [8:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    klen_reg = value;
  endtask

  // One phase sets a key length and then runs keyed sessions until its item
  // budget is used. A session loads each key byte that the schedule will read and that was never
  // loaded, reloads others at random, runs the schedule, and then streams data bytes.
  // The stream is mixed with a little noise: unused op codes, stray key loads
  // anywhere in the store, and an occasional re-key in the middle.
  task automatic run_phase(input logic [8:0] value, input bit with_hold);
    int done;
    int len;
    int run;
    int r;
    bit first;
    bit pressing;
    bit hold_pending;
    bit made;
    settle(SCHED_SETTLE);
    write_key_length(value);
    len = used_key_bytes();
    done = 0;
    first = 1'b1;
    hold_pending = 1'b0;
    while (done < PHASE_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      pressing = 1'b0;
      for (int idx = 0; idx < len; idx++) begin
        if (!key_known[idx] || $urandom_range(0, (len > 32) ? 15 : 2) == 0) begin
          send_item(OP_LOAD, byte_t'(idx), rand_byte(), made);
          done++;
        end
      end
      send_item(OP_SCHED, rand_byte(), rand_byte(), made);
      done++;
      run = $urandom_range(8, 40);
      // The receiver holds off once while the sender keeps offering data bytes
      // at full rate, so the block backs up into its input.
      if (with_hold && first) begin
        calm = 1'b1;
        pressing = 1'b1;
        run = 60;
        hold_pending = 1'b1;
      end
      first = 1'b0;
      repeat (run) begin
        r = $urandom_range(0, 99);
        if (pressing || r < 86) begin
          send_item(OP_DATA, rand_byte(), rand_byte(), made);
          // The hold starts once the schedule is over and the first byte is in.
          if (hold_pending) begin
            hold_req = 1'b1;
            hold_pending = 1'b0;
          end
        end else if (r < 91)
          send_item(OP_UNUSED, rand_byte(), rand_byte(), made);
        else if (r < 97)
          send_item(OP_LOAD, rand_byte(), rand_byte(), made);
        else
          send_item(OP_SCHED, rand_byte(), rand_byte(), made);
        done++;
      end
    end
  endtask

  // These are the opening directed transactions. Each row gives the op, the
  // key index and the byte. The last column is set where the row must not
  // produce a result. Data bytes come before any schedule, unused op codes
  // come both before and after keying, and the byte values go to their
  // extremes. A key load in the middle of the stream must not disturb the
  // cipher until the next schedule runs.
  typedef struct packed {
    logic [1:0] op;
    byte_t      kidx;
    byte_t      data;
    logic       silent;
  } plan_row_t;

  localparam int DIR_ROWS = 22;
  localparam plan_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_DATA,   8'h00, 8'h00, 1'b1},
    '{OP_DATA,   8'hFF, 8'hFF, 1'b1},
    '{OP_UNUSED, 8'hFF, 8'hFF, 1'b1},
    '{OP_LOAD,   8'h00, 8'h00, 1'b1},
    '{OP_LOAD,   8'hFF, 8'hFF, 1'b1},
    '{OP_SCHED,  8'h00, 8'h00, 1'b1},
    '{OP_DATA,   8'h00, 8'h00, 1'b0},
    '{OP_DATA,   8'h00, 8'hFF, 1'b0},
    '{OP_UNUSED, 8'h00, 8'h00, 1'b1},
    '{OP_DATA,   8'h00, 8'h5A, 1'b0},
    '{OP_DATA,   8'h00, 8'hA5, 1'b0},
    '{OP_LOAD,   8'h00, 8'hFF, 1'b1},
    '{OP_DATA,   8'h00, 8'h00, 1'b0},
    '{OP_SCHED,  8'hFF, 8'hFF, 1'b1},
    '{OP_DATA,   8'hFF, 8'h80, 1'b0},
    '{OP_DATA,   8'h00, 8'h01, 1'b0},
    '{OP_DATA,   8'h00, 8'h7F, 1'b0},
    '{OP_LOAD,   8'h80, 8'h55, 1'b1},
    '{OP_LOAD,   8'h7F, 8'hAA, 1'b1},
    '{OP_SCHED,  8'h00, 8'h00, 1'b1},
    '{OP_DATA,   8'h00, 8'hFE, 1'b0},
    '{OP_DATA,   8'h00, 8'h00, 1'b0}
  };

  // This is the stimulus and the run sequence. Reset is applied once, the key
  // length goes to one for the directed rows, and then the random phases walk
  // through several key lengths. Those include zero, which acts as one, and
  // the all-ones value, which is clipped to the full store.
  initial begin : stimulus
    bit made;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_op        <= OP_LOAD;
    in_key_index <= '0;
    in_byte_in   <= '0;
    errors   = 0;
    calm     = 1'b0;
    hold_req = 1'b0;
    keyed    = 1'b0;
    klen_reg = KLEN_RESET;
    pi = '0;
    pj = '0;
    pk = '0;
    stride  = '0;
    fb_byte = FEEDBACK_INIT;
    for (int n = 0; n < SBOX_DEPTH; n++)
      key_known[n] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_key_length(9'd1);
    for (int n = 0; n < DIR_ROWS; n++) begin
      send_item(DIRECTED[n].op, DIRECTED[n].kidx, DIRECTED[n].data, made);
      if (DIRECTED[n].silent && made) begin
        $error("directed row %0d: op %0d should produce no result", n, DIRECTED[n].op);
        errors++;
      end
    end

    run_phase(9'd0, 1'b0);
    run_phase(9'd511, 1'b0);
    run_phase(9'd256, 1'b0);
    run_phase(9'd16, 1'b1);
    run_phase(9'($urandom_range(2, 32)), 1'b0);
    run_phase(9'($urandom_range(33, 255)), 1'b0);
    run_phase(9'd1, 1'b0);
    run_phase(9'($urandom_range(0, 511)), 1'b0);

    settle(DRAIN_CYCLES);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // The receiver alternates stall runs of random length with short open
  // windows. It also serves the single long hold-off that the stimulus asks
  // for, counting it out here.
  initial begin : receiver
    int run;
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      run = idle_len();
      if (run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Each result transaction is matched against the oldest owed byte.
  always @(posedge clk) begin : check_results
    cipher_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $error("result with nothing owed: byte_out %02h keystream %02h",
               out_byte_out, out_keystream);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte_out !== want.byte_out) begin
          $error("byte_out: expected %02h, got %02h", want.byte_out, out_byte_out);
          errors++;
        end
        if (out_keystream !== want.keystream) begin
          $error("keystream: expected %02h, got %02h", want.keystream, out_keystream);
          errors++;
        end
      end
    end
  end

  // This is the watchdog. A correct run needs well under a tenth of this time.
  initial begin : watchdog
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/rc4v_pkg.sv
rtl/rc4v_ram.sv
rtl/rc4_variant_feedback_stream_cipher.sv
tb/rc4_variant_feedback_stream_cipher_tb.sv
